@@ hdl/u16d_pkg.sv @@
// ----------------------------------------------------------------------------
// u16d_pkg
// Shared types and constants of the UTF-16 byte stream decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package u16d_pkg;

  // Byte order of the stream; the last code has no meaning and is an error
  typedef enum logic [1:0] {
    BO_DETECT  = 2'd0,
    BO_BIG     = 2'd1,
    BO_LITTLE  = 2'd2,
    BO_INVALID = 2'd3
  } byte_order_e;

  localparam int unsigned ByteW = 8;
  localparam int unsigned UnitW = 16;
  localparam int unsigned CpW   = 21;
  localparam int unsigned SurW  = 10;

  localparam logic STATUS_OK  = 1'b0;
  localparam logic STATUS_ERR = 1'b1;

  localparam logic [UnitW-1:0] BOM_NATIVE  = 16'hFEFF;
  localparam logic [UnitW-1:0] BOM_SWAPPED = 16'hFFFE;
  localparam logic [CpW-1:0]   SUPP_BASE   = 21'h010000;
  localparam logic [CpW-1:0]   CP_MAX      = 21'h10FFFF;

  // Number of bytes of the current unit or pair taken in
  localparam logic [1:0] HELD_NONE      = 2'd0;
  localparam logic [1:0] HELD_ONE       = 2'd1;
  localparam logic [1:0] HELD_HIGH      = 2'd2;
  localparam logic [1:0] HELD_HIGH_BYTE = 2'd3;

  typedef struct packed {
    logic             valid;
    logic [CpW-1:0]   code_point;
    logic             status;
  } u16d_res_t;

  typedef struct packed {
    logic       we;
    logic [1:0] data;
  } u16d_cfg_t;

  function automatic logic is_high_sur(input logic [UnitW-1:0] u);
    return u[15:10] == 6'b110110;
  endfunction

  function automatic logic is_low_sur(input logic [UnitW-1:0] u);
    return u[15:10] == 6'b110111;
  endfunction

endpackage

`default_nettype wire

@@ hdl/u16d_in_stage.sv @@
// ----------------------------------------------------------------------------
// u16d_in_stage
// Input register: holds one raw byte until the decode stage takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module u16d_in_stage
  import u16d_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  input  wire logic [ByteW-1:0] data_byte_i,
  input  wire logic             advance_i,
  output logic                  valid_o,
  output logic [ByteW-1:0]      byte_o
);

  logic             valid_q, valid_d;
  logic [ByteW-1:0] byte_q;

  assign in_ready_o = !valid_q || advance_i;

  always_comb begin
    valid_d = valid_q;
    if (in_ready_o) begin
      valid_d = in_valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Payload: load on every accepted request
  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      byte_q <= data_byte_i;
    end
  end

  assign valid_o = valid_q;
  assign byte_o  = byte_q;

endmodule

`default_nettype wire

@@ hdl/u16d_core.sv @@
// ----------------------------------------------------------------------------
// u16d_core
// Decode state and single-pass unit assembly, BOM and surrogate handling.
// ----------------------------------------------------------------------------
`default_nettype none

module u16d_core
  import u16d_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire u16d_cfg_t        cfg_i,
  input  wire logic             fire_i,
  input  wire logic [ByteW-1:0] byte_i,
  output u16d_res_t             res_o
);

  byte_order_e      order_q, order_d;
  logic [1:0]       held_q, held_d;
  logic [ByteW-1:0] hbyte_q, hbyte_d;
  logic [SurW-1:0]  first_q, first_d;
  logic [UnitW-1:0] unit;
  logic             is_bom;

  always_comb begin
    unit   = (order_q == BO_LITTLE) ? {byte_i, hbyte_q} : {hbyte_q, byte_i};
    is_bom = (unit == BOM_NATIVE) || (unit == BOM_SWAPPED);

    order_d = order_q;
    held_d  = held_q;
    hbyte_d = hbyte_q;
    first_d = first_q;
    res_o   = '{valid: 1'b0, code_point: '0, status: STATUS_OK};

    case (held_q)
      HELD_NONE, HELD_HIGH: begin
        hbyte_d = byte_i;
        held_d  = held_q + 2'd1;
      end
      HELD_ONE: begin
        held_d  = HELD_NONE;
        hbyte_d = '0;
        first_d = '0;
        if (order_q == BO_DETECT && unit == BOM_NATIVE) begin
          order_d = BO_BIG;
        end else if (order_q == BO_DETECT && unit == BOM_SWAPPED) begin
          order_d = BO_LITTLE;
        end else if (order_q != BO_DETECT && is_bom) begin
          res_o = '{valid: 1'b1, code_point: '0, status: STATUS_ERR};
        end else begin
          if (order_q == BO_DETECT) begin
            order_d = BO_BIG;
          end
          if (is_high_sur(unit)) begin
            first_d = unit[SurW-1:0];
            held_d  = HELD_HIGH;
          end else begin
            res_o = '{valid: 1'b1, code_point: CpW'(unit), status: STATUS_OK};
          end
        end
      end
      HELD_HIGH_BYTE: begin
        held_d  = HELD_NONE;
        hbyte_d = '0;
        first_d = '0;
        if (is_low_sur(unit)) begin
          res_o = '{valid: 1'b1,
                    code_point: SUPP_BASE + CpW'({first_q, unit[SurW-1:0]}),
                    status: STATUS_OK};
        end else begin
          res_o = '{valid: 1'b1, code_point: '0, status: STATUS_ERR};
        end
      end
      default: begin
        held_d = HELD_NONE;
      end
    endcase

    // Meaningless byte order: error on every byte, keep state
    if (order_q == BO_INVALID) begin
      order_d = order_q;
      held_d  = held_q;
      hbyte_d = hbyte_q;
      first_d = first_q;
      res_o   = '{valid: 1'b1, code_point: '0, status: STATUS_ERR};
    end

    if (!fire_i) begin
      res_o.valid = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      order_q <= BO_DETECT;
      held_q  <= HELD_NONE;
      hbyte_q <= '0;
      first_q <= '0;
    end else if (cfg_i.we) begin
      // Restart the stream in the written byte order
      order_q <= byte_order_e'(cfg_i.data);
      held_q  <= HELD_NONE;
      hbyte_q <= '0;
      first_q <= '0;
    end else if (fire_i) begin
      order_q <= order_d;
      held_q  <= held_d;
      hbyte_q <= hbyte_d;
      first_q <= first_d;
    end
  end

endmodule

`default_nettype wire

@@ hdl/utf16_byte_stream_decoder.sv @@
// ----------------------------------------------------------------------------
// utf16_byte_stream_decoder
// UTF-16 byte stream to code point decoder with byte-order detection.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i/in_ready_o, data_byte_i) takes one raw byte
//   per request. Output channel (out_valid_o/out_ready_i) gives code_point_o
//   and status_o; a byte gives at most one result (the first byte of a unit,
//   a byte-order mark in detect mode and a high surrogate give none).
//   Configuration channel (cfg_valid_i/cfg_ready_o, start_byte_order_i) sets
//   the byte order (detect, big, little) and restarts the stream; write it
//   only while the block is idle.
//   Path: a completing byte waits in the input register, then its result in
//   the result register. Throughput: one byte per cycle while the receiver
//   does not stall, set by the single decode pass between the two registers.
//   Reset: byte order returns to detect, partial units are dropped, both
//   registers empty. When the receiver stalls the result register holds;
//   one more byte waits in the input register, then in_ready_o falls.
// ----------------------------------------------------------------------------
`default_nettype none

module utf16_byte_stream_decoder
  import u16d_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  input  wire logic [ByteW-1:0] data_byte_i,
  output logic                  out_valid_o,
  input  wire logic             out_ready_i,
  output logic [CpW-1:0]        code_point_o,
  output logic                  status_o,
  input  wire logic             cfg_valid_i,
  output logic                  cfg_ready_o,
  input  wire logic [1:0]       start_byte_order_i
);

  logic             s1_valid;
  logic [ByteW-1:0] s1_byte;
  logic             advance;
  u16d_res_t        res;
  u16d_cfg_t        cfg;
  logic             out_valid_q, out_valid_d;
  logic [CpW-1:0]   cp_q;
  logic             status_q;

  assign cfg_ready_o = 1'b1;
  assign cfg         = '{we: cfg_valid_i, data: start_byte_order_i};

  // Advance the decode pass only when the result register can take a result
  assign advance = s1_valid && (!out_valid_q || out_ready_i);

  u16d_in_stage u_in_stage (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .data_byte_i (data_byte_i),
    .advance_i   (advance),
    .valid_o     (s1_valid),
    .byte_o      (s1_byte)
  );

  u16d_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg),
    .fire_i (advance),
    .byte_i (s1_byte),
    .res_o  (res)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (advance) begin
      out_valid_d = res.valid;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && res.valid) begin
      cp_q     <= res.code_point;
      status_q <= res.status;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign code_point_o = cp_q;
  assign status_o     = status_q;

`ifndef SYNTHESIS
  a_err_zero_cp : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == STATUS_ERR |-> code_point_o == '0)
    else $error("error result carries a non-zero code point");

  a_cp_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> code_point_o <= CP_MAX)
    else $error("code point beyond the Unicode range");

  a_ready_only_on_stall : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i)
    else $error("input stalled while the result register could drain");

  a_no_result_without_byte : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$past(advance) && !$past(out_valid_o) |-> !out_valid_o)
    else $error("result appeared without a decoded byte");
`endif

endmodule

`default_nettype wire
